// ===== rtl/rrfs_pkg.sv =====
// Package for the region rotate frame store.
// Command and angle codes, controller states, datapath phases and the
// command/status structs between controller and datapath. No dependencies.
package rrfs_pkg;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_READ   = 2'd1,
		CMD_ROTATE = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		ANG_90   = 2'd0,
		ANG_180  = 2'd1,
		ANG_270  = 2'd2,
		ANG_NONE = 2'd3
	} angle_code_t;

	localparam logic [23:0] WHITE_PIXEL = 24'hFFFFFF;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SETUP2,
		S_DISPATCH,
		S_HA,
		S_HB,
		S_HW1,
		S_HW2,
		S_COPY,
		S_FILL,
		S_PUT,
		S_DRAIN,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		PH_NONE,
		PH_ACCESS,
		PH_HA,
		PH_HB,
		PH_HW1,
		PH_HW2,
		PH_COPY,
		PH_FILL,
		PH_PUT
	} phase_t;

	typedef struct packed {
		logic   capture;
		logic   setup1;
		logic   setup2;
		logic   cnt_clr;
		phase_t phase;
		logic   load_res;
	} ctl_cmd_t;

	typedef struct packed {
		cmd_code_t   cmd;
		angle_code_t angle;
		logic        err;
		logic        empty;
		logic        half_zero;
		logic        last;
		logic        last_pair;
	} dp_stat_t;

endpackage

// ===== rtl/rrfs_in_if.sv =====
// Request channel of the region rotate frame store.
// Valid/ready handshake with the command payload. No dependencies.
interface rrfs_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        command;
	logic [8:0]        start_x;
	logic [8:0]        start_y;
	logic signed [9:0] finish_x;
	logic signed [9:0] finish_y;
	logic [1:0]        angle_code;
	logic [7:0]        red_in;
	logic [7:0]        green_in;
	logic [7:0]        blue_in;

	modport source (
		output valid, command, start_x, start_y, finish_x, finish_y, angle_code,
		       red_in, green_in, blue_in,
		input  ready
	);
	modport sink (
		input  valid, command, start_x, start_y, finish_x, finish_y, angle_code,
		       red_in, green_in, blue_in,
		output ready
	);
endinterface

// ===== rtl/rrfs_out_if.sv =====
// Result channel of the region rotate frame store.
// Valid/ready handshake with pixel and status payload. No dependencies.
interface rrfs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       status;

	modport source (
		output valid, red_out, green_out, blue_out, status,
		input  ready
	);
	modport sink (
		input  valid, red_out, green_out, blue_out, status,
		output ready
	);
endinterface

// ===== rtl/rrfs_ctrl.sv =====
// Controller for the region rotate frame store: sequences access, swap,
// copy, fill and put phases. Depends on rrfs_pkg.
module rrfs_ctrl
	import rrfs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t st,
	output ctl_cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_res)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.phase    = PH_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.phase = PH_ACCESS;
				if (st.cmd == CMD_ROTATE && !st.err) begin
					cmd.setup1 = 1'b1;
					state_d    = S_SETUP2;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SETUP2: begin
				cmd.setup2 = 1'b1;
				state_d    = S_DISPATCH;
			end
			S_DISPATCH: begin
				cmd.cnt_clr = 1'b1;
				if (st.empty) begin
					state_d = S_DONE;
				end else begin
					unique case (st.angle)
						ANG_180: state_d = st.half_zero ? S_DONE : S_HA;
						ANG_90,
						ANG_270: state_d = S_COPY;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_HA: begin
				cmd.phase = PH_HA;
				state_d   = S_HB;
			end
			S_HB: begin
				cmd.phase = PH_HB;
				state_d   = S_HW1;
			end
			S_HW1: begin
				cmd.phase = PH_HW1;
				state_d   = S_HW2;
			end
			S_HW2: begin
				cmd.phase = PH_HW2;
				state_d   = st.last_pair ? S_DONE : S_HA;
			end
			S_COPY: begin
				cmd.phase = PH_COPY;
				if (st.last) state_d = S_FILL;
			end
			S_FILL: begin
				cmd.phase = PH_FILL;
				if (st.last) state_d = S_PUT;
			end
			S_PUT: begin
				cmd.phase = PH_PUT;
				if (st.last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_res = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== rtl/rrfs_dpath.sv =====
// Datapath for the region rotate frame store: config registers, region
// geometry, scan counters, pixel and scratch memories. Depends on rrfs_pkg.
module rrfs_dpath
	import rrfs_pkg::*;
#(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [8:0]        cfg_data,
	input  logic [1:0]        command,
	input  logic [8:0]        start_x,
	input  logic [8:0]        start_y,
	input  logic signed [9:0] finish_x,
	input  logic signed [9:0] finish_y,
	input  logic [1:0]        angle_code,
	input  logic [7:0]        red_in,
	input  logic [7:0]        green_in,
	input  logic [7:0]        blue_in,
	input  ctl_cmd_t          cmd,
	output dp_stat_t          st,
	output logic [7:0]        red_out,
	output logic [7:0]        green_out,
	output logic [7:0]        blue_out,
	output logic              status
);

	localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int CW0   = $clog2(MAXD + 1);
	localparam int CW    = (CW0 < 10) ? 10 : CW0;
	localparam int TW    = 2 * CW;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CW-1:0] MWC = CW'(MAX_WIDTH);
	localparam logic [CW-1:0] MHC = CW'(MAX_HEIGHT);
	localparam logic [TW-1:0] ROW_STRIDE = TW'(MAX_WIDTH);

	function automatic logic [AW-1:0] pix_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
		logic [TW-1:0] full;
		full = TW'(y) * ROW_STRIDE + TW'(x);
		return full[AW-1:0];
	endfunction

	// configuration
	logic [8:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) width_q <= cfg_data;
			else                   height_q <= cfg_data;
		end
	end

	// captured request
	cmd_code_t         cmd_q;
	angle_code_t       ang_q;
	logic [8:0]        sx_q, sy_q;
	logic signed [9:0] fx_q, fy_q;
	logic [23:0]       rgb_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= cmd_code_t'(command);
			ang_q <= angle_code_t'(angle_code);
			sx_q  <= start_x;
			sy_q  <= start_y;
			fx_q  <= finish_x;
			fy_q  <= finish_y;
			rgb_q <= {red_in, green_in, blue_in};
		end
	end

	logic [CW-1:0] w, h, sxe, sye, fxe, fye, cx, cy;
	logic          err;

	always_comb begin
		w   = (CW'(width_q) > MWC) ? MWC : CW'(width_q);
		h   = (CW'(height_q) > MHC) ? MHC : CW'(height_q);
		sxe = CW'(sx_q);
		sye = CW'(sy_q);
		fxe = CW'(fx_q[8:0]);
		fye = CW'(fy_q[8:0]);
		cx  = fx_q[9] ? '0 : ((fxe > w) ? w : fxe);
		cy  = fy_q[9] ? '0 : ((fye > h) ? h : fye);
		unique case (cmd_q)
			CMD_WRITE,
			CMD_READ:   err = (sxe >= w) || (sye >= h);
			CMD_ROTATE: err = (sxe > w) || (sye > h);
			default:    err = 1'b0;
		endcase
	end

	// region geometry
	logic [CW-1:0] x0_q, y0_q, m_q, n_q, q_q, qx_q, qy_q;
	logic [TW-1:0] total_q, half;

	always_ff @(posedge clk) begin
		if (cmd.setup1) begin
			x0_q <= (sxe < cx) ? sxe : cx;
			y0_q <= (sye < cy) ? sye : cy;
			m_q  <= (sxe < cx) ? cx - sxe : sxe - cx;
			n_q  <= (sye < cy) ? cy - sye : sye - cy;
		end
		if (cmd.setup2) begin
			q_q     <= (n_q < m_q) ? n_q : m_q;
			// centered square along the long side
			qx_q    <= x0_q + ((n_q < m_q) ? ((m_q - n_q) >> 1) : '0);
			qy_q    <= y0_q + ((n_q < m_q) ? '0 : ((n_q - m_q) >> 1));
			total_q <= TW'(m_q) * TW'(n_q);
		end
	end

	assign half = total_q >> 1;

	// scan counters: forward (u,r), backward (bu,br) for the point mirror
	logic [CW-1:0] u_q, r_q, bu_q, br_q, lx, ly;
	logic [TW-1:0] pc_q;
	logic          step, last, u_end;

	always_comb begin
		unique case (cmd.phase)
			PH_FILL, PH_HW2: begin lx = m_q; ly = n_q; end
			default:         begin lx = q_q; ly = q_q; end
		endcase
		u_end = (u_q == lx - 1'b1);
		last  = u_end && (r_q == ly - 1'b1);
		step  = (cmd.phase == PH_HW2) || (cmd.phase == PH_COPY) ||
		        (cmd.phase == PH_FILL) || (cmd.phase == PH_PUT);
	end

	always_ff @(posedge clk) begin
		if (cmd.cnt_clr) begin
			u_q  <= '0;
			r_q  <= '0;
			bu_q <= m_q - 1'b1;
			br_q <= n_q - 1'b1;
			pc_q <= '0;
		end else if (step) begin
			if (u_end) begin
				u_q <= '0;
				r_q <= (r_q == ly - 1'b1) ? '0 : r_q + 1'b1;
			end else begin
				u_q <= u_q + 1'b1;
			end
			if (cmd.phase == PH_HW2) begin
				if (bu_q == '0) begin
					bu_q <= m_q - 1'b1;
					br_q <= br_q - 1'b1;
				end else begin
					bu_q <= bu_q - 1'b1;
				end
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	// addresses
	logic [AW-1:0] a_addr, b_addr, sq_addr, pt_addr, scr_dst, scr_src;

	always_comb begin
		a_addr  = pix_addr(x0_q + u_q, y0_q + r_q);
		b_addr  = pix_addr(x0_q + bu_q, y0_q + br_q);
		sq_addr = pix_addr(qx_q + u_q, qy_q + r_q);
		pt_addr = pix_addr(sxe, sye);
		scr_dst = pix_addr(u_q, r_q);
		if (ang_q == ANG_90)
			scr_src = pix_addr(r_q, q_q - 1'b1 - u_q);
		else
			scr_src = pix_addr(q_q - 1'b1 - r_q, u_q);
	end

	// memories
	logic [23:0]   pix_mem [DEPTH];
	logic [23:0]   scr_mem [DEPTH];
	logic [23:0]   pix_rd_q, scr_rd_q, hold_q, pix_wdata;
	logic [AW-1:0] pix_raddr, pix_waddr, copy_addr_s1, put_addr_s1;
	logic          pix_re, pix_we, copy_we_s1, put_we_s1;

	always_comb begin
		pix_re    = 1'b0;
		pix_raddr = a_addr;
		unique case (cmd.phase)
			PH_ACCESS: begin
				pix_re    = (cmd_q == CMD_READ) && !err;
				pix_raddr = pt_addr;
			end
			PH_HA:   pix_re = 1'b1;
			PH_HB: begin
				pix_re    = 1'b1;
				pix_raddr = b_addr;
			end
			PH_COPY: begin
				pix_re    = 1'b1;
				pix_raddr = sq_addr;
			end
			default: pix_re = 1'b0;
		endcase
	end

	always_comb begin
		pix_we    = 1'b0;
		pix_waddr = a_addr;
		pix_wdata = pix_rd_q;
		if (put_we_s1) begin
			pix_we    = 1'b1;
			pix_waddr = put_addr_s1;
			pix_wdata = scr_rd_q;
		end else begin
			unique case (cmd.phase)
				PH_ACCESS: begin
					pix_we    = (cmd_q == CMD_WRITE) && !err;
					pix_waddr = pt_addr;
					pix_wdata = rgb_q;
				end
				PH_FILL: begin
					pix_we    = 1'b1;
					pix_wdata = WHITE_PIXEL;
				end
				PH_HW1:  pix_we = 1'b1;
				PH_HW2: begin
					pix_we    = 1'b1;
					pix_waddr = b_addr;
					pix_wdata = hold_q;
				end
				default: pix_we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pix_we) pix_mem[pix_waddr] <= pix_wdata;
		if (pix_re) pix_rd_q <= pix_mem[pix_raddr];
	end

	always_ff @(posedge clk) begin
		if (copy_we_s1) scr_mem[copy_addr_s1] <= pix_rd_q;
		if (cmd.phase == PH_PUT) scr_rd_q <= scr_mem[scr_src];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_we_s1 <= 1'b0;
			put_we_s1  <= 1'b0;
		end else begin
			copy_we_s1 <= (cmd.phase == PH_COPY);
			put_we_s1  <= (cmd.phase == PH_PUT);
		end
	end

	always_ff @(posedge clk) begin
		copy_addr_s1 <= scr_dst;
		put_addr_s1  <= sq_addr;
		if (cmd.phase == PH_HB) hold_q <= pix_rd_q;
	end

	// result register
	logic [23:0] res_q;
	logic        status_q;

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			res_q    <= ((cmd_q == CMD_READ) && !err) ? pix_rd_q : '0;
			status_q <= err;
		end
	end

	assign red_out   = res_q[23:16];
	assign green_out = res_q[15:8];
	assign blue_out  = res_q[7:0];
	assign status    = status_q;

	always_comb begin
		st           = '0;
		st.cmd       = cmd_q;
		st.angle     = ang_q;
		st.err       = err;
		st.empty     = (m_q == '0) || (n_q == '0);
		st.half_zero = (half == '0);
		st.last      = last;
		st.last_pair = (pc_q == half - 1'b1);
	end

endmodule

// ===== rtl/region_rotate_frame_store.sv =====
// Region rotate frame store, top level. One request at a time.
// Rotate 180 swaps point-mirrored pixel pairs, two reads and two writes per pair
// (one pixel memory, used in the HA, HB, HW1 and HW2 phases in turn).
// Rotate 90/270: copy, white fill, put; one pixel a cycle.
// Reset clears control state and image size; pixel memory is undefined until written.
module region_rotate_frame_store
	import rrfs_pkg::*;
#(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	rrfs_in_if.sink    in_ch,
	rrfs_out_if.source out_ch,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data
);

	ctl_cmd_t cmd;
	dp_stat_t st;
	logic     in_ready, out_valid;

	rrfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.st        (st),
		.cmd       (cmd)
	);

	rrfs_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.command    (in_ch.command),
		.start_x    (in_ch.start_x),
		.start_y    (in_ch.start_y),
		.finish_x   (in_ch.finish_x),
		.finish_y   (in_ch.finish_y),
		.angle_code (in_ch.angle_code),
		.red_in     (in_ch.red_in),
		.green_in   (in_ch.green_in),
		.blue_in    (in_ch.blue_in),
		.cmd        (cmd),
		.st         (st),
		.red_out    (out_ch.red_out),
		.green_out  (out_ch.green_out),
		.blue_out   (out_ch.blue_out),
		.status     (out_ch.status)
	);

	assign in_ch.ready  = in_ready;
	assign out_ch.valid = out_valid;

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("request taken while busy");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_res |-> (!out_ch.valid || out_ch.ready))
		else $error("result overwritten before taken");

	a_rotate_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.setup1 |-> !st.err)
		else $error("rotate started with corner outside image");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for region_rotate_frame_store: pixel write/read and region rotates,
// checked against an in-bench pixel store model. Depends on rrfs_pkg and the channel interfaces.
module testbench;
	import rrfs_pkg::*;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;
	localparam int   DIM        = 256;
	localparam int   NRAND      = 16;

	typedef struct {
		cmd_code_t         cmd;
		logic [8:0]        sx;
		logic [8:0]        sy;
		logic signed [9:0] fx;
		logic signed [9:0] fy;
		angle_code_t       angle;
		logic [23:0]       rgb;
	} pix_req_t;

	typedef struct {
		logic [23:0] rgb;
		logic        status;
	} pix_resp_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [8:0] cfg_data;

	rrfs_in_if  in_ch ();
	rrfs_out_if out_ch ();

	region_rotate_frame_store i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// model state
	logic [23:0] frame [DIM*DIM];
	logic [23:0] square [DIM*DIM];
	logic [8:0]  img_w_reg;
	logic [8:0]  img_h_reg;

	pix_resp_t pending_resp [$];
	int        errors;
	int        hold_cycles;
	bit        no_idle;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("tb: failure");
		$finish;
	end

	function automatic int pix_addr(int x, int y);
		return (y % DIM) * DIM + (x % DIM);
	endfunction

	function automatic int eff_w();
		return img_w_reg > DIM ? DIM : int'(img_w_reg);
	endfunction

	function automatic int eff_h();
		return img_h_reg > DIM ? DIM : int'(img_h_reg);
	endfunction

	function automatic int clamp_corner(logic signed [9:0] v, int hi);
		int s;
		s = v;
		if (s < 0) return 0;
		if (s > hi) return hi;
		return s;
	endfunction

	function automatic void swap_half(int x0, int y0, int m, int n);
		int total, p, q, a, b;
		logic [23:0] t;
		total = m * n;
		for (p = 0; p < total / 2; p++) begin
			q = total - 1 - p;
			a = pix_addr(x0 + p % m, y0 + p / m);
			b = pix_addr(x0 + q % m, y0 + q / m);
			t = frame[a];
			frame[a] = frame[b];
			frame[b] = t;
		end
	endfunction

	function automatic void turn_square(int x0, int y0, int m, int n, bit cw);
		int q, qx, qy, r, u, src;
		q  = n < m ? n : m;
		qx = x0 + (n < m ? (m - n) / 2 : 0);
		qy = y0 + (n < m ? 0 : (n - m) / 2);
		for (r = 0; r < q; r++)
			for (u = 0; u < q; u++)
				square[pix_addr(u, r)] = frame[pix_addr(qx + u, qy + r)];
		for (r = 0; r < n; r++)
			for (u = 0; u < m; u++)
				frame[pix_addr(x0 + u, y0 + r)] = WHITE_PIXEL;
		for (r = 0; r < q; r++)
			for (u = 0; u < q; u++) begin
				src = cw ? pix_addr(r, q - 1 - u) : pix_addr(q - 1 - r, u);
				frame[pix_addr(qx + u, qy + r)] = square[src];
			end
	endfunction

	// applies one request to the model and returns the expected response
	function automatic pix_resp_t apply_request(pix_req_t rq);
		pix_resp_t rs;
		int w, h, cx, cy, x0, y0, m, n;
		rs.rgb = '0;
		rs.status = 1'b0;
		w = eff_w();
		h = eff_h();
		if (rq.cmd == CMD_WRITE || rq.cmd == CMD_READ) begin
			if (rq.sx >= w || rq.sy >= h)
				rs.status = 1'b1;
			else if (rq.cmd == CMD_WRITE)
				frame[pix_addr(rq.sx, rq.sy)] = rq.rgb;
			else
				rs.rgb = frame[pix_addr(rq.sx, rq.sy)];
		end else if (rq.cmd == CMD_ROTATE) begin
			if (rq.sx > w || rq.sy > h) begin
				rs.status = 1'b1;
			end else begin
				cx = clamp_corner(rq.fx, w);
				cy = clamp_corner(rq.fy, h);
				x0 = rq.sx < cx ? int'(rq.sx) : cx;
				y0 = rq.sy < cy ? int'(rq.sy) : cy;
				m  = rq.sx < cx ? cx - rq.sx : rq.sx - cx;
				n  = rq.sy < cy ? cy - rq.sy : rq.sy - cy;
				if (m != 0 && n != 0) begin
					if (rq.angle == ANG_180)
						swap_half(x0, y0, m, n);
					else if (rq.angle == ANG_90)
						turn_square(x0, y0, m, n, 1'b1);
					else if (rq.angle == ANG_270)
						turn_square(x0, y0, m, n, 1'b0);
				end
			end
		end
		return rs;
	endfunction

	task automatic report(string what, logic [23:0] got, logic [23:0] want);
		$display("tb: mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// response side: random stalls, or a long counted hold-off when asked
	initial begin
		int stall;
		pix_resp_t want;
		out_ch.ready <= 1'b0;
		forever begin
			if (hold_cycles > 0) begin
				stall = hold_cycles;
				hold_cycles = 0;
			end else if (no_idle) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 19);
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			if (pending_resp.size() == 0) begin
				report("unexpected response", {out_ch.red_out, out_ch.green_out,
					out_ch.blue_out}, '0);
			end else begin
				want = pending_resp.pop_front();
				if (out_ch.red_out !== want.rgb[23:16])
					report("red", out_ch.red_out, want.rgb[23:16]);
				if (out_ch.green_out !== want.rgb[15:8])
					report("green", out_ch.green_out, want.rgb[15:8]);
				if (out_ch.blue_out !== want.rgb[7:0])
					report("blue", out_ch.blue_out, want.rgb[7:0]);
				if (out_ch.status !== want.status)
					report("status", out_ch.status, want.status);
			end
		end
	end

	task automatic send_request(pix_req_t rq, bit last);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.command    <= rq.cmd;
		in_ch.start_x    <= rq.sx;
		in_ch.start_y    <= rq.sy;
		in_ch.finish_x   <= rq.fx;
		in_ch.finish_y   <= rq.fy;
		in_ch.angle_code <= rq.angle;
		in_ch.red_in     <= rq.rgb[23:16];
		in_ch.green_in   <= rq.rgb[15:8];
		in_ch.blue_in    <= rq.rgb[7:0];
		do @(posedge clk); while (!in_ch.ready);
		pending_resp.push_back(apply_request(rq));
		if (last)
			in_ch.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_resp.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [8:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WIDTH) img_w_reg = val;
		else img_h_reg = val;
	endtask

	function automatic pix_req_t make_req(cmd_code_t c, int sx, int sy, int fx, int fy,
		angle_code_t a, logic [23:0] rgb);
		pix_req_t rq;
		rq.cmd = c;
		rq.sx = 9'(sx);
		rq.sy = 9'(sy);
		rq.fx = 10'(fx);
		rq.fy = 10'(fy);
		rq.angle = a;
		rq.rgb = rgb;
		return rq;
	endfunction

	// sets the image size and writes every pixel so later reads stay defined
	task automatic load_image(logic [8:0] w, logic [8:0] h);
		int x, y;
		wait_idle();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		for (y = 0; y < eff_h(); y++)
			for (x = 0; x < eff_w(); x++)
				send_request(make_req(CMD_WRITE, x, y, $urandom, $urandom, ANG_90,
					24'($urandom)), 1'b0);
	endtask

	function automatic pix_req_t random_req();
		pix_req_t rq;
		int w, h, pick;
		w = eff_w();
		h = eff_h();
		rq.rgb   = 24'($urandom);
		rq.angle = angle_code_t'($urandom_range(0, 3));
		rq.fx    = 10'($urandom);
		rq.fy    = 10'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 35) rq.cmd = CMD_READ;
		else if (pick < 65) rq.cmd = CMD_WRITE;
		else if (pick < 95) rq.cmd = CMD_ROTATE;
		else rq.cmd = CMD_NONE;
		if ($urandom_range(0, 9) == 0 || w == 0 || h == 0) begin
			rq.sx = 9'($urandom);
			rq.sy = 9'($urandom);
		end else if (rq.cmd == CMD_ROTATE) begin
			rq.sx = 9'($urandom_range(0, w));
			rq.sy = 9'($urandom_range(0, h));
			if ($urandom_range(0, 7) != 0) begin
				rq.fx = 10'(int'($urandom_range(0, w + 4)) - 2);
				rq.fy = 10'(int'($urandom_range(0, h + 4)) - 2);
			end
		end else begin
			rq.sx = 9'($urandom_range(0, w - 1));
			rq.sy = 9'($urandom_range(0, h - 1));
		end
		if (rq.angle == ANG_NONE && $urandom_range(0, 3) != 0)
			rq.angle = ANG_180;
		return rq;
	endfunction

	task automatic test_empty_image();
		send_request(make_req(CMD_WRITE, 0, 0, 0, 0, ANG_90, 24'h123456), 1'b0);
		send_request(make_req(CMD_READ, 0, 0, 0, 0, ANG_90, '0), 1'b0);
		send_request(make_req(CMD_ROTATE, 0, 0, 511, 511, ANG_90, '0), 1'b0);
		send_request(make_req(CMD_ROTATE, 1, 0, 5, 5, ANG_180, '0), 1'b0);
		send_request(make_req(CMD_NONE, 511, 511, -512, -512, ANG_NONE, '1), 1'b1);
	endtask

	task automatic test_directed();
		load_image(9'd8, 9'd6);
		send_request(make_req(CMD_WRITE, 0, 0, 0, 0, ANG_90, 24'h000000), 1'b0);
		send_request(make_req(CMD_WRITE, 7, 5, 0, 0, ANG_90, 24'hFFFFFF), 1'b0);
		send_request(make_req(CMD_READ, 0, 0, 0, 0, ANG_90, '0), 1'b0);
		send_request(make_req(CMD_READ, 7, 5, 0, 0, ANG_90, '0), 1'b0);
		send_request(make_req(CMD_READ, 8, 0, 0, 0, ANG_90, '0), 1'b0);
		send_request(make_req(CMD_WRITE, 0, 6, 0, 0, ANG_90, 24'hABCDEF), 1'b0);
		send_request(make_req(CMD_READ, 511, 511, 0, 0, ANG_90, '0), 1'b0);
		send_request(make_req(CMD_ROTATE, 0, 0, 8, 6, ANG_90, '0), 1'b0);
		send_request(make_req(CMD_ROTATE, 0, 0, 8, 6, ANG_180, '0), 1'b0);
		send_request(make_req(CMD_ROTATE, 8, 6, 1, 2, ANG_270, '0), 1'b0);
		// finish corners far outside get clamped
		send_request(make_req(CMD_ROTATE, 3, 4, -512, 511, ANG_90, '0), 1'b0);
		send_request(make_req(CMD_ROTATE, 2, 1, 511, -512, ANG_270, '0), 1'b0);
		send_request(make_req(CMD_ROTATE, 9, 0, 0, 0, ANG_90, '0), 1'b0);
		send_request(make_req(CMD_ROTATE, 0, 7, 0, 0, ANG_180, '0), 1'b0);
		send_request(make_req(CMD_ROTATE, 3, 2, 3, 5, ANG_90, '0), 1'b0);
		send_request(make_req(CMD_ROTATE, 0, 0, 8, 6, ANG_NONE, '0), 1'b0);
		send_request(make_req(CMD_NONE, 1, 1, 4, 4, ANG_180, '1), 1'b0);
		send_request(make_req(CMD_ROTATE, 1, 1, 6, 2, ANG_180, '0), 1'b0);
		for (int y = 0; y < 6; y++)
			send_request(make_req(CMD_READ, y, y, 0, 0, ANG_90, '0), y == 5);
	endtask

	task automatic test_random_sizes();
		logic [8:0] ws [6] = '{9'd5, 9'd511, 9'd1, 9'd8, 9'd3, 9'd2};
		logic [8:0] hs [6] = '{9'd4, 9'd1, 9'd12, 9'd6, 9'd2, 9'd3};
		for (int k = 0; k < 6; k++) begin
			load_image(ws[k], hs[k]);
			no_idle = (k == 3);
			for (int i = 0; i < NRAND; i++)
				send_request(random_req(), i == NRAND - 1);
			no_idle = 1'b0;
		end
	endtask

	// response side stalls for a long stretch while requests keep coming
	task automatic test_backpressure();
		load_image(9'd4, 9'd4);
		in_ch.valid <= 1'b0;
		wait_idle();
		hold_cycles = 400;
		no_idle = 1'b1;
		for (int i = 0; i < 30; i++)
			send_request(make_req(i % 2 ? CMD_READ : CMD_WRITE, i % 4, (i / 4) % 4, 0, 0,
				ANG_90, 24'($urandom)), i == 29);
		no_idle = 1'b0;
	endtask

	initial begin
		errors      = 0;
		hold_cycles = 0;
		no_idle     = 1'b0;
		img_w_reg   = '0;
		img_h_reg   = '0;
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= REG_WIDTH;
		cfg_data    <= '0;
		in_ch.valid <= 1'b0;
		in_ch.command    <= CMD_NONE;
		in_ch.start_x    <= '0;
		in_ch.start_y    <= '0;
		in_ch.finish_x   <= '0;
		in_ch.finish_y   <= '0;
		in_ch.angle_code <= ANG_NONE;
		in_ch.red_in     <= '0;
		in_ch.green_in   <= '0;
		in_ch.blue_in    <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_image();
		test_directed();
		test_random_sizes();
		test_backpressure();
		wait_idle();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// ===== region_rotate_frame_store.f =====
rtl/rrfs_pkg.sv
rtl/rrfs_in_if.sv
rtl/rrfs_out_if.sv
rtl/rrfs_ctrl.sv
rtl/rrfs_dpath.sv
rtl/region_rotate_frame_store.sv
tb/testbench.sv
